>>> hdl/qte_pkg.sv
// qte_pkg: shared widths, constants and the CORDIC arctangent table
// for the quaternion to Euler angle converter. No dependencies.
package qte_pkg;

  localparam int unsigned QUAT_BITS_DEF  = 16;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned Q30_BITS     = 32;
  localparam int unsigned T_BITS       = 34;
  localparam int unsigned CW_BITS      = 38;
  localparam int unsigned Z_BITS       = 34;
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned SQRT_STAGES  = 31;
  localparam int unsigned ALIGN_STAGES = 3 + SQRT_STAGES;

  localparam logic signed [63:0] ONE60 = 64'sd1 <<< 60;
  localparam logic signed [T_BITS-1:0] ONE30 = 34'sd1 <<< 30;
  localparam logic signed [Z_BITS-1:0] ANG_HALF_PI = 34'sd1686629713;

  typedef logic signed [T_BITS-1:0] t_val_t;
  typedef logic signed [Z_BITS-1:0] z_val_t;

  function automatic z_val_t atan_entry(input int unsigned i);
    z_val_t r;
    r = '0;
    unique case (i)
      0:  r = 34'sh03243F6A8;
      1:  r = 34'sh01DAC6705;
      2:  r = 34'sh00FADBAFC;
      3:  r = 34'sh007F56EA6;
      4:  r = 34'sh003FEAB76;
      5:  r = 34'sh001FFD55B;
      6:  r = 34'sh000FFFAAA;
      7:  r = 34'sh0007FFF55;
      8:  r = 34'sh0003FFFEA;
      9:  r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      24: r = 34'sh00000003F;
      25: r = 34'sh00000001F;
      26: r = 34'sh00000000F;
      27: r = 34'sh000000008;
      28: r = 34'sh000000004;
      29: r = 34'sh000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/qte_front.sv
// qte_front: quaternion products and the five doubled product sums.
// Two register stages. Depends on qte_pkg.
module qte_front #(
  parameter int unsigned QUAT_BITS = qte_pkg::QUAT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [QUAT_BITS-1:0] quat_w_i,
  input  logic signed [QUAT_BITS-1:0] quat_x_i,
  input  logic signed [QUAT_BITS-1:0] quat_y_i,
  input  logic signed [QUAT_BITS-1:0] quat_z_i,
  output logic                        valid_o,
  output qte_pkg::t_val_t             t0_o,
  output qte_pkg::t_val_t             t1_o,
  output qte_pkg::t_val_t             t2_o,
  output qte_pkg::t_val_t             t3_o,
  output qte_pkg::t_val_t             t4_o
);
  import qte_pkg::*;

  logic signed [QUAT_BITS-1:0] comp [4];
  logic signed [Q30_BITS-1:0]  q30  [4];

  assign comp[0] = quat_w_i;
  assign comp[1] = quat_x_i;
  assign comp[2] = quat_y_i;
  assign comp[3] = quat_z_i;

  for (genvar k = 0; k < 4; k++) begin : g_q30
    if (QUAT_BITS <= 31) begin : g_up
      assign q30[k] = Q30_BITS'(comp[k]) <<< (31 - QUAT_BITS);
    end else begin : g_down
      assign q30[k] = Q30_BITS'(comp[k] >>> 1);
    end
  end

  logic valid_a_q, valid_b_q;
  logic signed [63:0] p_yy_q, p_zz_q, p_xx_q, p_xy_q, p_wz_q, p_wy_q, p_xz_q, p_yz_q, p_wx_q;
  logic signed [63:0] p_yy_d, p_zz_d, p_xx_d, p_xy_d, p_wz_d, p_wy_d, p_xz_d, p_yz_d, p_wx_d;
  t_val_t t0_q, t1_q, t2_q, t3_q, t4_q;
  t_val_t t0_d, t1_d, t2_d, t3_d, t4_d;

  always_comb begin
    p_yy_d = q30[2] * q30[2];
    p_zz_d = q30[3] * q30[3];
    p_xx_d = q30[1] * q30[1];
    p_xy_d = q30[1] * q30[2];
    p_wz_d = q30[0] * q30[3];
    p_wy_d = q30[0] * q30[2];
    p_xz_d = q30[1] * q30[3];
    p_yz_d = q30[2] * q30[3];
    p_wx_d = q30[0] * q30[1];
  end

  always_comb begin
    t0_d = T_BITS'((ONE60 - ((p_yy_q + p_zz_q) <<< 1)) >>> 30);
    t1_d = T_BITS'(((p_xy_q + p_wz_q) <<< 1) >>> 30);
    t2_d = T_BITS'(((p_wy_q - p_xz_q) <<< 1) >>> 30);
    t3_d = T_BITS'(((p_yz_q + p_wx_q) <<< 1) >>> 30);
    t4_d = T_BITS'((ONE60 - ((p_xx_q + p_yy_q) <<< 1)) >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_yy_q <= p_yy_d;
      p_zz_q <= p_zz_d;
      p_xx_q <= p_xx_d;
      p_xy_q <= p_xy_d;
      p_wz_q <= p_wz_d;
      p_wy_q <= p_wy_d;
      p_xz_q <= p_xz_d;
      p_yz_q <= p_yz_d;
      p_wx_q <= p_wx_d;
      t0_q   <= t0_d;
      t1_q   <= t1_d;
      t2_q   <= t2_d;
      t3_q   <= t3_d;
      t4_q   <= t4_d;
    end
  end

  assign valid_o = valid_b_q;
  assign t0_o    = t0_q;
  assign t1_o    = t1_q;
  assign t2_o    = t2_q;
  assign t3_o    = t3_q;
  assign t4_o    = t4_q;

endmodule

>>> hdl/qte_isqrt.sv
// qte_isqrt: clamps the pitch term, squares it and takes the floor square root
// of one minus the square, one result bit per stage. Depends on qte_pkg.
module qte_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qte_pkg::t_val_t t2_i,
  output logic            valid_o,
  output qte_pkg::t_val_t t2c_o,
  output qte_pkg::t_val_t root_o
);
  import qte_pkg::*;

  logic        valid_c_q, valid_d_q, valid_e_q;
  logic signed [31:0] t2c_d, t2c_c_q, t2c_dd_q, t2c_e_q;
  logic signed [63:0] sq_q;
  logic        [63:0] n_q;

  always_comb begin
    priority if (t2_i > ONE30) begin
      t2c_d = 32'(ONE30);
    end else if (t2_i < -ONE30) begin
      t2c_d = 32'(-ONE30);
    end else begin
      t2c_d = t2_i[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else if (en_i) begin
      valid_c_q <= valid_i;
      valid_d_q <= valid_c_q;
      valid_e_q <= valid_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2c_c_q  <= t2c_d;
      sq_q     <= t2c_c_q * t2c_c_q;
      t2c_dd_q <= t2c_c_q;
      n_q      <= 64'(ONE60 - sq_q);
      t2c_e_q  <= t2c_dd_q;
    end
  end

  logic        [63:0] rem_q  [SQRT_STAGES+1];
  logic        [31:0] root_q [SQRT_STAGES+1];
  logic signed [31:0] side_q [SQRT_STAGES+1];
  logic               vld_q  [SQRT_STAGES+1];

  assign rem_q[0]  = n_q;
  assign root_q[0] = '0;
  assign side_q[0] = t2c_e_q;
  assign vld_q[0]  = valid_e_q;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
    localparam int unsigned K = SQRT_STAGES - 1 - j;
    logic [63:0] trial;
    logic [63:0] rem_d;
    logic [31:0] root_d;

    always_comb begin
      trial = (64'(root_q[j]) << (K + 1)) | (64'd1 << (2 * K));
      if (rem_q[j] >= trial) begin
        rem_d  = rem_q[j] - trial;
        root_d = root_q[j] | (32'd1 << K);
      end else begin
        rem_d  = rem_q[j];
        root_d = root_q[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = vld_q[SQRT_STAGES];
  assign t2c_o   = T_BITS'(side_q[SQRT_STAGES]);
  assign root_o  = T_BITS'({1'b0, root_q[SQRT_STAGES]});

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c_q |-> (t2c_c_q <= 32'(ONE30)) && (t2c_c_q >= 32'(-ONE30)))
    else $error("clamped pitch term out of range");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> root_q[SQRT_STAGES] <= 32'(ONE30))
    else $error("square root exceeds one");

  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rem_q[SQRT_STAGES] <= (64'(root_q[SQRT_STAGES]) << 1))
    else $error("square root remainder too large");

endmodule

>>> hdl/qte_cordic.sv
// qte_cordic: pipelined CORDIC vectoring atan2 with quadrant pre-rotation
// and rounding to the output angle format. Depends on qte_pkg.
module qte_cordic #(
  parameter int unsigned ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF,
  parameter int unsigned OUT_BITS   = qte_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  qte_pkg::t_val_t            y_i,
  input  qte_pkg::t_val_t            x_i,
  output logic                       valid_o,
  output logic signed [OUT_BITS-1:0] angle_o
);
  import qte_pkg::*;

  localparam int unsigned SH = 33 - ANGLE_BITS;

  logic signed [CW_BITS-1:0] x_q [CORDIC_ITERS+1];
  logic signed [CW_BITS-1:0] y_q [CORDIC_ITERS+1];
  z_val_t                    z_q [CORDIC_ITERS+1];
  logic                      zero_q [CORDIC_ITERS+1];
  logic                      vld_q  [CORDIC_ITERS+1];

  logic signed [CW_BITS-1:0] xe, ye, x0_d, y0_d;
  z_val_t                    z0_d;

  always_comb begin
    xe = CW_BITS'(x_i);
    ye = CW_BITS'(y_i);
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        z0_d = ANG_HALF_PI;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        z0_d = -ANG_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [CW_BITS-1:0] dx, dy, x_d, y_d;
    z_val_t                    z_d;

    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      if (y_q[i] >= 0) begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + atan_entry(i);
      end else begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - atan_entry(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  z_val_t zr;
  logic   valid_r_q;
  logic signed [OUT_BITS-1:0] angle_q;

  always_comb begin
    if (zero_q[CORDIC_ITERS]) begin
      zr = '0;
    end else begin
      zr = (z_q[CORDIC_ITERS] + (34'sd1 <<< (SH - 1))) >>> SH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_r_q <= 1'b0;
    end else if (en_i) begin
      valid_r_q <= vld_q[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zr[OUT_BITS-1:0];
    end
  end

  assign valid_o = valid_r_q;
  assign angle_o = angle_q;

endmodule

>>> hdl/quaternion_to_euler_unit.sv
// quaternion_to_euler_unit: top level, ZYX Euler angles from a quaternion.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
//
// Takes one quaternion beat (Q1.(QUAT_BITS-1)) per cycle while in_stall_o is low and
// returns roll and yaw in Q3.(ANGLE_BITS-3) radians and pitch in Q2.(ANGLE_BITS-3)
// radians, one result beat per input beat, in order. Throughput is one beat per clock
// when not stalled. The path runs through the product sums, the clamp and square of
// the pitch term, the bit-per-stage square root, the 30-step CORDIC with pre-rotation
// and rounding, and one output register. The whole pipeline holds while a result
// beat waits on out_stall_i.
module quaternion_to_euler_unit #(
  parameter int unsigned QUAT_BITS  = qte_pkg::QUAT_BITS_DEF,
  parameter int unsigned ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [QUAT_BITS-1:0]  quat_w_i,
  input  logic signed [QUAT_BITS-1:0]  quat_x_i,
  input  logic signed [QUAT_BITS-1:0]  quat_y_i,
  input  logic signed [QUAT_BITS-1:0]  quat_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ANGLE_BITS-1:0] roll_o,
  output logic signed [ANGLE_BITS-2:0] pitch_o,
  output logic signed [ANGLE_BITS-1:0] yaw_o
);
  import qte_pkg::*;

  localparam int PITCH_LIM = int'(ANG_HALF_PI >>> (33 - ANGLE_BITS)) + 2;

  logic   en;
  logic   out_valid_q;
  logic   f_valid, s_valid, r_valid, p_valid, y_valid;
  t_val_t t0, t1, t2, t3, t4, t2c, root;
  logic signed [ANGLE_BITS-1:0] r_angle, y_angle;
  logic signed [ANGLE_BITS-2:0] p_angle;
  logic signed [ANGLE_BITS-1:0] roll_q, yaw_q;
  logic signed [ANGLE_BITS-2:0] pitch_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  qte_front #(.QUAT_BITS(QUAT_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (f_valid),
    .t0_o     (t0),
    .t1_o     (t1),
    .t2_o     (t2),
    .t3_o     (t3),
    .t4_o     (t4)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .t2_i    (t2),
    .valid_o (s_valid),
    .t2c_o   (t2c),
    .root_o  (root)
  );

  qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(ANGLE_BITS)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .y_i     (t3),
    .x_i     (t4),
    .valid_o (r_valid),
    .angle_o (r_angle)
  );

  qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(ANGLE_BITS - 1)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .y_i     (t2c),
    .x_i     (root),
    .valid_o (p_valid),
    .angle_o (p_angle)
  );

  qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(ANGLE_BITS)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .y_i     (t1),
    .x_i     (t0),
    .valid_o (y_valid),
    .angle_o (y_angle)
  );

  logic signed [ANGLE_BITS-1:0] roll_dly_q [ALIGN_STAGES];
  logic signed [ANGLE_BITS-1:0] yaw_dly_q  [ALIGN_STAGES];
  logic                         vld_dly_q  [ALIGN_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ALIGN_STAGES; k++) begin
        vld_dly_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_dly_q[0] <= r_valid && y_valid;
      for (int k = 1; k < ALIGN_STAGES; k++) begin
        vld_dly_q[k] <= vld_dly_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_dly_q[0] <= r_angle;
      yaw_dly_q[0]  <= y_angle;
      for (int k = 1; k < ALIGN_STAGES; k++) begin
        roll_dly_q[k] <= roll_dly_q[k-1];
        yaw_dly_q[k]  <= yaw_dly_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p_valid && vld_dly_q[ALIGN_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_dly_q[ALIGN_STAGES-1];
      pitch_q <= p_angle;
      yaw_q   <= yaw_dly_q[ALIGN_STAGES-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_o      = roll_q;
  assign pitch_o     = pitch_q;
  assign yaw_o       = yaw_q;

  a_paths_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid == vld_dly_q[ALIGN_STAGES-1])
    else $error("pitch and roll/yaw paths out of step");

  a_roll_yaw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid == y_valid)
    else $error("roll and yaw paths out of step");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input held with no result beat waiting");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(pitch_o) <= PITCH_LIM) && (int'(pitch_o) >= -PITCH_LIM))
    else $error("pitch beyond half pi");

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for quaternion_to_euler_unit. Holds a scoreboard class
// with a bit-exact ZYX angle predictor. Depends on qte_pkg and the unit's RTL.
module tb_top;
  import qte_pkg::*;

  localparam int QB = QUAT_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;
  localparam int SH = 30 - (AB - 3);
  localparam int NUM_RAND = 1680;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [AB-1:0] roll;
    logic signed [AB-2:0] pitch;
    logic signed [AB-1:0] yaw;
  } angles_t;

  class euler_scoreboard;
    angles_t pending[$];
    int errors = 0;
    longint arctan_q30[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

    function longint vector_angle(longint yv, longint xv);
      longint z, t, dx, dy;
      z = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
        t = xv;
        if (yv >= 0) begin
          xv = yv; yv = -t; z = ANG_HALF_PI;
        end else begin
          xv = -yv; yv = t; z = -ANG_HALF_PI;
        end
      end
      for (int i = 0; i < 30; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; z += arctan_q30[i];
        end else begin
          xv -= dx; yv += dy; z -= arctan_q30[i];
        end
      end
      return z;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint round_angle(longint z);
      return (z + (64'sd1 <<< (SH - 1))) >>> SH;
    endfunction

    function void note(logic signed [QB-1:0] qw, qx, qy, qz);
      longint w, x, y, z, one60, one30, t0, t1, t2, t3, t4, c, r;
      angles_t a;
      one60 = 64'sd1 <<< 60;
      one30 = 64'sd1 <<< 30;
      w = longint'(qw) <<< (31 - QB);
      x = longint'(qx) <<< (31 - QB);
      y = longint'(qy) <<< (31 - QB);
      z = longint'(qz) <<< (31 - QB);
      t0 = (one60 - 2 * (y * y + z * z)) >>> 30;
      t1 = (2 * (x * y + w * z)) >>> 30;
      t2 = (2 * (w * y - x * z)) >>> 30;
      t3 = (2 * (y * z + w * x)) >>> 30;
      t4 = (one60 - 2 * (x * x + y * y)) >>> 30;
      if (t2 > one30) t2 = one30;
      if (t2 < -one30) t2 = -one30;
      c = longint'(root_floor(longint'(one60 - t2 * t2)));
      r = round_angle(vector_angle(t3, t4));
      a.roll = r[AB-1:0];
      r = round_angle(vector_angle(t2, c));
      a.pitch = r[AB-2:0];
      r = round_angle(vector_angle(t1, t0));
      a.yaw = r[AB-1:0];
      pending = {pending, a};
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check(angles_t got);
      angles_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.roll !== want.roll) report("roll", got.roll, want.roll);
      if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
      if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [QB-1:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic in_stall_o, out_valid_o;
  logic signed [AB-1:0] roll_o, yaw_o;
  logic signed [AB-2:0] pitch_o;

  euler_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int idle_count = 0;

  quaternion_to_euler_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .out_valid_o, .out_stall_i, .roll_o, .pitch_o, .yaw_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (out_valid_o && !out_stall_i) sb.check('{roll_o, pitch_o, yaw_o});
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
        out_stall_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 3);
        out_stall_i = 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task send_beat(logic signed [QB-1:0] w, x, y, z);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    quat_w_i = w; quat_x_i = x; quat_y_i = y; quat_z_i = z;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(w, x, y, z);
    @(negedge clk_i);
  endtask

  task send_random();
    real a, b, c, d, n;
    int k, s;
    logic signed [QB-1:0] q[4];
    k = $urandom_range(0, 99);
    if (k < 15) begin
      for (int i = 0; i < 4; i++) q[i] = QB'($urandom());
    end else if (k < 30) begin
      s = $urandom_range(23100, 23240);
      q[0] = QB'($urandom_range(0, 1) ? s : -s);
      q[2] = QB'($urandom_range(0, 1) ? s : -s);
      q[1] = QB'(int'($urandom_range(0, 200)) - 100);
      q[3] = QB'(int'($urandom_range(0, 200)) - 100);
    end else begin
      a = $urandom_range(0, 65534) - 32767.0;
      b = $urandom_range(0, 65534) - 32767.0;
      c = $urandom_range(0, 65534) - 32767.0;
      d = $urandom_range(0, 65534) - 32767.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 1.0; n = 1.0;
      end
      q[0] = QB'($rtoi(a / n * 32767.0));
      q[1] = QB'($rtoi(b / n * 32767.0));
      q[2] = QB'($rtoi(c / n * 32767.0));
      q[3] = QB'($rtoi(d / n * 32767.0));
    end
    send_beat(q[0], q[1], q[2], q[3]);
  endtask

  localparam logic signed [QB-1:0] PMAX = 16'sh7FFF;
  localparam logic signed [QB-1:0] NMAX = 16'sh8000;
  localparam logic signed [QB-1:0] HALF = 16'sd23170;

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_beat(0, 0, 0, 0);
    send_beat(PMAX, 0, 0, 0);
    send_beat(NMAX, 0, 0, 0);
    send_beat(0, PMAX, 0, 0);
    send_beat(0, 0, PMAX, 0);
    send_beat(0, 0, 0, PMAX);
    send_beat(0, 0, 0, NMAX);
    send_beat(0, NMAX, 0, 0);
    send_beat(PMAX, PMAX, PMAX, PMAX);
    send_beat(NMAX, NMAX, NMAX, NMAX);
    send_beat(PMAX, NMAX, PMAX, NMAX);
    send_beat(PMAX, 0, PMAX, 0);
    send_beat(PMAX, 0, NMAX, 0);
    send_beat(0, PMAX, 0, NMAX);
    send_beat(HALF, 0, HALF, 0);
    send_beat(HALF, 0, -HALF, 0);
    send_beat(HALF, HALF, 0, 0);
    send_beat(HALF, 0, 0, -HALF);
    send_beat(1, -1, 1, -1);
    send_beat(16384, 16384, 16384, 16384);
    for (int i = 0; i < NUM_RAND; i++) begin
      if (i == 400) hold_req = 1;
      if (i == 800) begin
        in_valid_i = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      if (i == NUM_RAND - 300) quiet = 1;
      send_random();
    end
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_unit.sv
bench/tb_top.sv
